// File: design/double_hash_table_engine_unit_assert.svh
// Assertion macros shared by the checker of the double hash table engine
`ifndef DOUBLE_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle
`define DHTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle
`define DHTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/dhte_pkg.sv
// Types and constants of the double hash table engine
`timescale 1ns / 1ps

package dhte_pkg;

	localparam int CAPACITY   = 1024;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int SIZE_W     = 11;
	localparam int KEY_W      = 31;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int CNT_W      = $clog2(KEY_W);

	// Fold count after which the key is below 1024 (2^10 = 24 mod 1000)
	localparam int FOLD_LAST  = 6;

	localparam logic [SIZE_W-1:0] STEP_MOD   = SIZE_W'(1000);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1000);

	localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

	localparam logic REQ_INSERT = 1'b0;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD_STEP,
		S_MOD_HOME,
		S_MOD_STEP2,
		S_PROBE,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              used;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} slot_t;

endpackage

// File: design/double_hash_table_engine_unit.sv
// Top level of the double hash table engine: modulo sequencer, probe loop and slot memory
// Sequence: the key is folded to key mod 1000, then the shared modulo unit makes two
// 31-bit restoring passes, then each probe reads the slot memory and then checks the slot.
// Throughput: one request at a time; the next is taken only once the result has been accepted.
// Reset: table size goes to 1000; a clearing pass over all 1024 slots marks every slot empty,
// with no request taken meanwhile.
`timescale 1ns / 1ps

module double_hash_table_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,   // table_size
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // key [30:0], data [62:31], zero [63]
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // found_data
	output logic [2:0]  m_axis_tuser   // status
);

	dhte_pkg::state_t state_q, state_d;

	logic [dhte_pkg::SIZE_W-1:0]   size_q;
	logic [dhte_pkg::SIZE_W-1:0]   eff_size;
	logic [dhte_pkg::IDX_W-1:0]    clr_q;
	logic                          req_q;
	logic [dhte_pkg::KEY_W-1:0]    key_q;
	logic [dhte_pkg::DATA_W-1:0]   data_q;
	logic [dhte_pkg::KEY_W-1:0]    quo_q;
	logic [dhte_pkg::IDX_W-1:0]    rem_q;
	logic [dhte_pkg::CNT_W-1:0]    cnt_q;
	logic [dhte_pkg::IDX_W-1:0]    m1000_q;
	logic [dhte_pkg::IDX_W-1:0]    home_q;
	logic [dhte_pkg::IDX_W-1:0]    step_q;
	logic [dhte_pkg::IDX_W-1:0]    idx_q;
	logic [dhte_pkg::SIZE_W-1:0]   n_q;
	logic                          first_q;
	logic [dhte_pkg::STATUS_W-1:0] status_q;
	logic [dhte_pkg::DATA_W-1:0]   fdata_q;

	logic [dhte_pkg::SIZE_W-1:0]   divisor;
	logic [dhte_pkg::SIZE_W-1:0]   trial;
	logic [dhte_pkg::IDX_W-1:0]    rem_nxt;
	logic                          mod_last;
	logic [dhte_pkg::KEY_W-1:0]    fold_nxt;
	logic [dhte_pkg::IDX_W-1:0]    fold_rem;
	logic                          fold_last;
	logic [dhte_pkg::SIZE_W-1:0]   idx_sum;
	logic [dhte_pkg::IDX_W-1:0]    idx_nxt;

	dhte_pkg::slot_t mem [dhte_pkg::CAPACITY];
	dhte_pkg::slot_t rdata_q;
	dhte_pkg::slot_t mem_wdata;
	logic [dhte_pkg::IDX_W-1:0] mem_waddr;
	logic                       mem_we;

	logic                          hit;
	logic                          finish;
	logic                          advance;
	logic [dhte_pkg::STATUS_W-1:0] outcome;

	// Clamp table size to 1..CAPACITY
	always_comb begin
		eff_size = size_q;
		if (size_q == '0)
			eff_size = dhte_pkg::SIZE_W'(1);
		else if (size_q > dhte_pkg::SIZE_W'(dhte_pkg::CAPACITY))
			eff_size = dhte_pkg::SIZE_W'(dhte_pkg::CAPACITY);
	end

	// Fold the key by 2^10 = 24 mod 1000, then one compare and subtract
	assign fold_nxt  = dhte_pkg::KEY_W'({quo_q[dhte_pkg::KEY_W-1:dhte_pkg::IDX_W], 4'b0000})
	                 + dhte_pkg::KEY_W'({quo_q[dhte_pkg::KEY_W-1:dhte_pkg::IDX_W], 3'b000})
	                 + dhte_pkg::KEY_W'(quo_q[dhte_pkg::IDX_W-1:0]);
	assign fold_rem  = (quo_q[dhte_pkg::IDX_W-1:0] >= dhte_pkg::STEP_MOD[dhte_pkg::IDX_W-1:0])
	                 ? quo_q[dhte_pkg::IDX_W-1:0] - dhte_pkg::STEP_MOD[dhte_pkg::IDX_W-1:0]
	                 : quo_q[dhte_pkg::IDX_W-1:0];
	assign fold_last = (cnt_q == dhte_pkg::CNT_W'(dhte_pkg::FOLD_LAST));

	// Shared restoring modulo unit: one dividend bit per cycle
	assign divisor  = eff_size;
	assign trial    = {rem_q, quo_q[dhte_pkg::KEY_W-1]};
	assign rem_nxt  = (trial >= divisor) ? dhte_pkg::IDX_W'(trial - divisor)
	                                     : trial[dhte_pkg::IDX_W-1:0];
	assign mod_last = (cnt_q == dhte_pkg::CNT_W'(dhte_pkg::KEY_W - 1));

	// Next probe slot; both terms lie below the size
	assign idx_sum = {1'b0, idx_q} + {1'b0, step_q};
	assign idx_nxt = (idx_sum >= eff_size) ? dhte_pkg::IDX_W'(idx_sum - eff_size)
	                                       : idx_sum[dhte_pkg::IDX_W-1:0];

	// Decide the outcome of the slot just read
	always_comb begin
		hit     = rdata_q.used && (rdata_q.key == key_q);
		finish  = 1'b0;
		advance = 1'b0;
		outcome = dhte_pkg::ST_MISSING;
		if (req_q == dhte_pkg::REQ_INSERT) begin
			if (hit) begin
				finish  = 1'b1;
				outcome = dhte_pkg::ST_UPDATED;
			end else if (!rdata_q.used) begin
				finish  = 1'b1;
				outcome = dhte_pkg::ST_NEW;
			end else if ((first_q && step_q == '0) || (!first_q && idx_q == home_q)) begin
				finish  = 1'b1;
				outcome = dhte_pkg::ST_FULL;
			end else begin
				advance = 1'b1;
			end
		end else begin
			if (!rdata_q.used) begin
				finish  = 1'b1;
				outcome = dhte_pkg::ST_MISSING;
			end else if (hit) begin
				finish  = 1'b1;
				outcome = dhte_pkg::ST_FOUND;
			end else if (n_q + dhte_pkg::SIZE_W'(1) >= eff_size) begin
				finish  = 1'b1;
				outcome = dhte_pkg::ST_MISSING;
			end else begin
				advance = 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dhte_pkg::S_CLEAR:
				if (clr_q == '1) state_d = dhte_pkg::S_IDLE;
			dhte_pkg::S_IDLE:
				if (s_axis_tvalid) state_d = dhte_pkg::S_MOD_STEP;
			dhte_pkg::S_MOD_STEP:
				if (fold_last) state_d = dhte_pkg::S_MOD_HOME;
			dhte_pkg::S_MOD_HOME:
				if (mod_last) state_d = dhte_pkg::S_MOD_STEP2;
			dhte_pkg::S_MOD_STEP2:
				if (mod_last) state_d = dhte_pkg::S_PROBE;
			dhte_pkg::S_PROBE:
				state_d = dhte_pkg::S_CHECK;
			dhte_pkg::S_CHECK:
				state_d = finish ? dhte_pkg::S_DONE : dhte_pkg::S_PROBE;
			dhte_pkg::S_DONE:
				if (m_axis_tready) state_d = dhte_pkg::S_IDLE;
			default:
				state_d = dhte_pkg::S_IDLE;
		endcase
	end

	// Outputs and memory write port
	always_comb begin
		s_axis_tready = (state_q == dhte_pkg::S_IDLE);
		m_axis_tvalid = (state_q == dhte_pkg::S_DONE);
		m_axis_tuser  = status_q;
		m_axis_tdata  = fdata_q;
		mem_we        = 1'b0;
		mem_waddr     = idx_q;
		mem_wdata     = '{used: 1'b1, key: key_q, data: data_q};
		if (state_q == dhte_pkg::S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '{used: 1'b0, key: '0, data: '0};
		end else if (state_q == dhte_pkg::S_CHECK && finish &&
		             (outcome == dhte_pkg::ST_NEW || outcome == dhte_pkg::ST_UPDATED)) begin
			mem_we = 1'b1;
		end
	end

	// Slot memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[idx_q];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhte_pkg::S_CLEAR;
			size_q  <= dhte_pkg::SIZE_RESET;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				size_q <= cfg_wr_data;
			if (state_q == dhte_pkg::S_CLEAR)
				clr_q <= clr_q + dhte_pkg::IDX_W'(1);
		end
	end

	// Datapath: request capture, modulo passes, probe walk, result
	always_ff @(posedge clk) begin
		unique case (state_q)
			dhte_pkg::S_IDLE: begin
				req_q  <= s_axis_tuser;
				key_q  <= s_axis_tdata[dhte_pkg::KEY_W-1:0];
				data_q <= s_axis_tdata[dhte_pkg::KEY_W +: dhte_pkg::DATA_W];
				quo_q  <= s_axis_tdata[dhte_pkg::KEY_W-1:0];
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			dhte_pkg::S_MOD_STEP: begin
				if (fold_last) begin
					m1000_q <= fold_rem;
					quo_q   <= key_q;
					rem_q   <= '0;
					cnt_q   <= '0;
				end else begin
					quo_q <= fold_nxt;
					cnt_q <= cnt_q + dhte_pkg::CNT_W'(1);
				end
			end
			dhte_pkg::S_MOD_HOME, dhte_pkg::S_MOD_STEP2: begin
				if (mod_last) begin
					rem_q <= '0;
					cnt_q <= '0;
					if (state_q == dhte_pkg::S_MOD_HOME) begin
						home_q <= rem_nxt;
						quo_q  <= {{(dhte_pkg::KEY_W-dhte_pkg::IDX_W){1'b0}}, m1000_q};
					end else begin
						step_q  <= rem_nxt;
						idx_q   <= home_q;
						first_q <= 1'b1;
						n_q     <= '0;
					end
				end else begin
					rem_q <= rem_nxt;
					quo_q <= {quo_q[dhte_pkg::KEY_W-2:0], 1'b0};
					cnt_q <= cnt_q + dhte_pkg::CNT_W'(1);
				end
			end
			dhte_pkg::S_CHECK: begin
				if (advance) begin
					idx_q   <= idx_nxt;
					first_q <= 1'b0;
					n_q     <= n_q + dhte_pkg::SIZE_W'(1);
				end
				if (finish) begin
					status_q <= outcome;
					fdata_q  <= (outcome == dhte_pkg::ST_FOUND) ? rdata_q.data : '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/dhte_checker.sv
// Port checker of the double hash table engine, bound to the top level
`timescale 1ns / 1ps
`include "double_hash_table_engine_unit_assert.svh"

module dhte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [10:0] cfg_wr_data,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	// Hold a stalled result
	`DHTE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tuser) && $stable(m_axis_tdata), "stalled result changed")
	// One request in flight
	`DHTE_ASSERT_NOW(a_one_inflight, m_axis_tvalid, !s_axis_tready, "input ready while result pending")
	`DHTE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "request accepted back to back")
	// Status is a known code, and data is zero unless found
	`DHTE_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == dhte_pkg::ST_NEW || m_axis_tuser == dhte_pkg::ST_UPDATED || m_axis_tuser == dhte_pkg::ST_FULL || m_axis_tuser == dhte_pkg::ST_FOUND || m_axis_tuser == dhte_pkg::ST_MISSING, "bad status")
	`DHTE_ASSERT_NOW(a_zero_data, m_axis_tvalid && m_axis_tuser != dhte_pkg::ST_FOUND, m_axis_tdata == '0, "data set without a hit")

endmodule

bind double_hash_table_engine_unit dhte_checker u_dhte_checker (.*);
